[rtl/fbr_pkg.sv]
// Shared types, widths and helper functions for the framebuffer rasterizer.
// Has no dependencies. The rasterizer top level uses it.
package fbr_pkg;

  // Default frame size
  localparam int FB_WIDTH  = 256;
  localparam int FB_HEIGHT = 256;

  // Field widths
  localparam int MODE_W    = 2;
  localparam int CRD_W     = 16;
  localparam int COL_W     = 24;
  localparam int PIX_W     = 8;
  localparam int RAD_W     = 8;
  localparam int CNT_W     = 17;
  localparam int REG_IDX_W = 2;

  // Packed beat widths (whole bytes)
  localparam int IN_W  = 136;
  localparam int OUT_W = 48;

  // Datapath widths: box coordinates, multiplier operands and products, edge accumulators
  localparam int BW = 14;
  localparam int OW = 18;
  localparam int PW = 36;
  localparam int EW = 40;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_BG_COLOR   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DISC_RAD   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DISC_COLOR = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_TRI   = 2'd1,
    MODE_DISC  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOX,
    ST_MUL,
    ST_CHECK,
    ST_SCAN,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  // 12.4 value divided by 16, truncated toward zero, sign-extended to BW bits
  function automatic logic signed [BW-1:0] trunc16(input logic signed [CRD_W-1:0] v);
    logic signed [CRD_W:0] t;
    t = {v[CRD_W-1], v} + (v[CRD_W-1] ? 17'sd15 : 17'sd0);
    return {{(BW-12){t[CRD_W-1]}}, t[CRD_W-1:4]};
  endfunction

  function automatic logic signed [CRD_W-1:0] min3(input logic signed [CRD_W-1:0] a,
                                                   input logic signed [CRD_W-1:0] b,
                                                   input logic signed [CRD_W-1:0] c);
    logic signed [CRD_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [CRD_W-1:0] max3(input logic signed [CRD_W-1:0] a,
                                                   input logic signed [CRD_W-1:0] b,
                                                   input logic signed [CRD_W-1:0] c);
    logic signed [CRD_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // a - b as an OW-bit signed operand
  function automatic logic signed [OW-1:0] diff(input logic signed [CRD_W-1:0] a,
                                                input logic signed [CRD_W-1:0] b);
    return {{(OW-CRD_W){a[CRD_W-1]}}, a} - {{(OW-CRD_W){b[CRD_W-1]}}, b};
  endfunction

  // 16 * (a - b) as an EW-bit signed edge increment
  function automatic logic signed [EW-1:0] step16(input logic signed [CRD_W-1:0] a,
                                                  input logic signed [CRD_W-1:0] b);
    logic signed [CRD_W:0] d;
    d = {a[CRD_W-1], a} - {b[CRD_W-1], b};
    return {{(EW-CRD_W-5){d[CRD_W]}}, d, 4'b0000};
  endfunction

endpackage

[rtl/fbr_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
// Depends on nothing; width and depth come from parameters.
module fbr_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 65536
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [DATA_W-1:0]          wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [DATA_W-1:0]          rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/framebuffer_triangle_disc_rasterizer.sv]
// Framebuffer rasterizer top level: clear, triangle, disc and pixel read over one frame RAM.
// Depends on fbr_pkg and fbr_ram.
//
// One operation is in flight at a time; its result beat sits in an output register, so the
// next operation is taken while that beat waits. All drawing goes through the single RAM
// write port at one pixel per cycle. A clear walks the whole frame; a triangle or disc
// steps through accept, bounding box, five steps of edge or distance start values through a
// shared pair of 18x18 multipliers and a check, then scans each pixel of its clipped
// bounding box, (2*radius+1)^2 at most for a disc, and hands off its result; a culled
// triangle or an empty box skips the scan; a read issues, waits for the RAM data and hands
// off its result. Pixels are stored at address {y, x}, so the RAM is
// HEIGHT * 2^clog2(WIDTH) words deep. The RAM comes up with undefined contents and is not
// swept after reset: clear the frame before reading it.
module framebuffer_triangle_disc_rasterizer #(
  parameter int WIDTH  = fbr_pkg::FB_WIDTH,
  parameter int HEIGHT = fbr_pkg::FB_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  // in beat
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: ax, ay, by_coord... from bit 0: ax[15:0], ay[31:16], bx[47:32], by_coord[63:48],
  // cx[79:64], cy[95:80], tri_color[119:96], pixel_x[127:120], pixel_y[135:128]
  input  logic [fbr_pkg::IN_W-1:0]      s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [fbr_pkg::MODE_W-1:0]    s_axis_tuser,
  // result beat
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: pixel_value[23:0], pixels_written[40:24], zero fill above
  output logic [fbr_pkg::OUT_W-1:0]     m_axis_tdata,
  // tuser: culled[0]
  output logic [0:0]                    m_axis_tuser,
  // register writes
  input  logic                          cfg_we,
  input  logic [fbr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [fbr_pkg::COL_W-1:0]     cfg_data
);
  import fbr_pkg::*;

  localparam int XW    = $clog2(WIDTH);
  localparam int YW    = $clog2(HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = HEIGHT * (2 ** XW);
  localparam logic signed [BW-1:0] XMAX = BW'(WIDTH - 1);
  localparam logic signed [BW-1:0] YMAX = BW'(HEIGHT - 1);

  // Unpacked input fields
  logic signed [CRD_W-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
  logic [COL_W-1:0]        in_color;
  logic [PIX_W-1:0]        in_px, in_py;
  mode_t                   in_mode;
  logic                    in_accept;
  logic                    in_range;

  assign in_ax    = s_axis_tdata[15:0];
  assign in_ay    = s_axis_tdata[31:16];
  assign in_bx    = s_axis_tdata[47:32];
  assign in_by    = s_axis_tdata[63:48];
  assign in_cx    = s_axis_tdata[79:64];
  assign in_cy    = s_axis_tdata[95:80];
  assign in_color = s_axis_tdata[119:96];
  assign in_px    = s_axis_tdata[127:120];
  assign in_py    = s_axis_tdata[135:128];
  assign in_mode  = mode_t'(s_axis_tuser);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_range  = (BW'(in_px) < BW'(WIDTH)) && (BW'(in_py) < BW'(HEIGHT));

  // Configuration registers
  logic [COL_W-1:0] bg_color;
  logic [RAD_W-1:0] disc_radius;
  logic [COL_W-1:0] disc_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_color    <= '0;
      disc_radius <= RAD_W'(4);
      disc_color  <= {COL_W{1'b1}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BG_COLOR:   bg_color    <= cfg_data;
        REG_DISC_RAD:   disc_radius <= cfg_data[RAD_W-1:0];
        REG_DISC_COLOR: disc_color  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Control state
  state_t     state, state_next;
  logic       out_free;
  logic [2:0] mstep;

  // Operation registers
  mode_t                   op_mode;
  logic signed [CRD_W-1:0] ax, ay, bx, by, cx, cy;
  logic [COL_W-1:0]        op_color;
  logic [AW-1:0]           rd_addr;

  // Bounding box and disc offsets
  logic signed [BW-1:0] x0, x1, y0, y1, dx0, dy0;
  logic signed [BW-1:0] dxv, dyv;

  // Edge increments, start values and running values
  logic signed [EW-1:0] sx0, sx1, sx2, sy0, sy1, sy2;
  logic signed [EW-1:0] area, e0, e1, e2, r0, r1, r2;
  logic signed [PW-1:0] p1, p2;

  // Scan position and results
  logic [XW-1:0]    x;
  logic [YW-1:0]    y;
  logic [CNT_W-1:0] count;
  logic [COL_W-1:0] value;
  logic             culled;
  logic [COL_W-1:0] rd_data;

  // Bounding box from registered vertices
  logic signed [BW-1:0] tx0, tx1, ty0, ty1, fx, fy, rr;
  logic signed [BW-1:0] dlx, dhx, dly, dhy, bx0, bx1, by0, by1;

  always_comb begin
    tx0 = trunc16(min3(ax, bx, cx));
    tx1 = trunc16(max3(ax, bx, cx));
    ty0 = trunc16(min3(ay, by, cy));
    ty1 = trunc16(max3(ay, by, cy));
    fx  = trunc16(ax);
    fy  = trunc16(ay);
    rr  = $signed({{(BW-RAD_W){1'b0}}, disc_radius});
    dlx = fx - rr;
    dhx = fx + rr;
    dly = fy - rr;
    dhy = fy + rr;
    if (op_mode == MODE_TRI) begin
      bx0 = (tx0 < 0) ? '0 : ((tx0 > XMAX) ? XMAX : tx0);
      by0 = (ty0 < 0) ? '0 : ((ty0 > YMAX) ? YMAX : ty0);
      bx1 = (tx1 > XMAX) ? XMAX : tx1;
      by1 = (ty1 > YMAX) ? YMAX : ty1;
    end else begin
      bx0 = (dlx < 0) ? '0 : dlx;
      by0 = (dly < 0) ? '0 : dly;
      bx1 = (dhx > XMAX) ? XMAX : dhx;
      by1 = (dhy > YMAX) ? YMAX : dhy;
    end
  end

  // Multiplier operands for each setup step
  logic signed [OW-1:0] qx, qy, ma1, mb1, ma2, mb2;
  logic signed [EW-1:0] mres;

  assign qx = {x0, 4'b0000};
  assign qy = {y0, 4'b0000};

  always_comb begin
    ma1 = '0;
    mb1 = '0;
    ma2 = '0;
    mb2 = '0;
    if (op_mode == MODE_TRI) begin
      case (mstep)
        3'd0: begin
          ma1 = diff(bx, ax); mb1 = diff(cy, ay);
          ma2 = diff(by, ay); mb2 = diff(cx, ax);
        end
        3'd1: begin
          ma1 = diff(bx, ax); mb1 = qy - {{(OW-CRD_W){ay[CRD_W-1]}}, ay};
          ma2 = diff(by, ay); mb2 = qx - {{(OW-CRD_W){ax[CRD_W-1]}}, ax};
        end
        3'd2: begin
          ma1 = diff(cx, bx); mb1 = qy - {{(OW-CRD_W){by[CRD_W-1]}}, by};
          ma2 = diff(cy, by); mb2 = qx - {{(OW-CRD_W){bx[CRD_W-1]}}, bx};
        end
        3'd3: begin
          ma1 = diff(ax, cx); mb1 = qy - {{(OW-CRD_W){cy[CRD_W-1]}}, cy};
          ma2 = diff(ay, cy); mb2 = qx - {{(OW-CRD_W){cx[CRD_W-1]}}, cx};
        end
        default: ;
      endcase
    end else begin
      // disc: radius squared, then squared distance of the box corner (p1 - p2 with p2 negated)
      case (mstep)
        3'd0: begin
          ma1 = {{(OW-BW){1'b0}}, rr};
          mb1 = {{(OW-BW){1'b0}}, rr};
        end
        3'd1: begin
          ma1 = {{(OW-BW){dx0[BW-1]}}, dx0};
          mb1 = {{(OW-BW){dx0[BW-1]}}, dx0};
          ma2 = {{(OW-BW){dy0[BW-1]}}, dy0};
          mb2 = -{{(OW-BW){dy0[BW-1]}}, dy0};
        end
        default: ;
      endcase
    end
  end

  assign mres = {{(EW-PW){p1[PW-1]}}, p1} - {{(EW-PW){p2[PW-1]}}, p2};

  // Pixel test at the current scan position
  logic pix_hit, tri_hit, disc_hit, last_x, last_y;
  logic cull, box_empty;

  assign tri_hit  = (e0 > 0) && (e1 > 0) && (e2 > 0);
  assign disc_hit = (e0 <= area);
  assign last_x   = (x == x1[XW-1:0]);
  assign last_y   = (y == y1[YW-1:0]);
  assign cull     = (op_mode == MODE_TRI) && (area <= 0);
  assign box_empty = (x1 < x0) || (y1 < y0);

  always_comb begin
    unique case (op_mode)
      MODE_CLEAR: pix_hit = 1'b1;
      MODE_TRI:   pix_hit = tri_hit;
      MODE_DISC:  pix_hit = disc_hit;
      MODE_READ:  pix_hit = 1'b0;
    endcase
  end

  // Next state and handshake
  logic ram_we, ram_re;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          unique case (in_mode)
            MODE_CLEAR: state_next = ST_SCAN;
            MODE_TRI:   state_next = ST_BOX;
            MODE_DISC:  state_next = ST_BOX;
            MODE_READ:  state_next = in_range ? ST_RD_ISSUE : ST_DONE;
          endcase
        end
      end
      ST_BOX:   state_next = ST_MUL;
      ST_MUL:   if (mstep == 3'd4) state_next = ST_CHECK;
      ST_CHECK: state_next = (cull || box_empty) ? ST_DONE : ST_SCAN;
      ST_SCAN: begin
        ram_we = pix_hit;
        if (last_x && last_y) state_next = ST_DONE;
      end
      ST_RD_ISSUE: begin
        ram_re     = 1'b1;
        state_next = ST_RD_WAIT;
      end
      ST_RD_WAIT: state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          op_mode <= in_mode;
          ax <= in_ax;
          ay <= in_ay;
          bx <= in_bx;
          by <= in_by;
          cx <= in_cx;
          cy <= in_cy;
          rd_addr <= {YW'(in_py), XW'(in_px)};
          count   <= '0;
          value   <= '0;
          culled  <= 1'b0;
          mstep   <= '0;
          unique case (in_mode)
            MODE_CLEAR: op_color <= bg_color;
            MODE_TRI:   op_color <= in_color;
            MODE_DISC:  op_color <= disc_color;
            MODE_READ:  op_color <= in_color;
          endcase
          // clear walks the whole frame
          x  <= '0;
          y  <= '0;
          x0 <= '0;
          y0 <= '0;
          x1 <= XMAX;
          y1 <= YMAX;
        end
      end
      ST_BOX: begin
        x0  <= bx0;
        x1  <= bx1;
        y0  <= by0;
        y1  <= by1;
        dx0 <= bx0 - fx;
        dy0 <= by0 - fy;
        sx0 <= step16(ay, by);
        sy0 <= step16(bx, ax);
        sx1 <= step16(by, cy);
        sy1 <= step16(cx, bx);
        sx2 <= step16(cy, ay);
        sy2 <= step16(ax, cx);
      end
      ST_MUL: begin
        p1    <= ma1 * mb1;
        p2    <= ma2 * mb2;
        mstep <= mstep + 3'd1;
        // store the product pair issued on the previous step
        unique case (mstep)
          3'd1: area <= mres;
          3'd2: begin e0 <= mres; r0 <= mres; end
          3'd3: begin e1 <= mres; r1 <= mres; end
          3'd4: begin e2 <= mres; r2 <= mres; end
          default: ;
        endcase
      end
      ST_CHECK: begin
        culled <= cull;
        x      <= x0[XW-1:0];
        y      <= y0[YW-1:0];
        dxv    <= dx0;
        dyv    <= dy0;
      end
      ST_SCAN: begin
        if (pix_hit) count <= count + CNT_W'(1);
        if (last_x) begin
          x   <= x0[XW-1:0];
          y   <= y + YW'(1);
          dxv <= dx0;
          dyv <= dyv + BW'(1);
          if (op_mode == MODE_DISC) begin
            r0 <= r0 + {{(EW-BW-1){dyv[BW-1]}}, dyv, 1'b1};
            e0 <= r0 + {{(EW-BW-1){dyv[BW-1]}}, dyv, 1'b1};
          end else begin
            r0 <= r0 + sy0;
            r1 <= r1 + sy1;
            r2 <= r2 + sy2;
            e0 <= r0 + sy0;
            e1 <= r1 + sy1;
            e2 <= r2 + sy2;
          end
        end else begin
          x   <= x + XW'(1);
          dxv <= dxv + BW'(1);
          if (op_mode == MODE_DISC) begin
            e0 <= e0 + {{(EW-BW-1){dxv[BW-1]}}, dxv, 1'b1};
          end else begin
            e0 <= e0 + sx0;
            e1 <= e1 + sx1;
            e2 <= e2 + sx2;
          end
        end
      end
      ST_RD_ISSUE: ;
      ST_RD_WAIT:  value <= rd_data;
      ST_DONE:     ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= {{(OUT_W-COL_W-CNT_W){1'b0}}, count, value};
      m_axis_tuser <= culled;
    end
  end

  // Frame store
  fbr_ram #(
    .DATA_W (COL_W),
    .DEPTH  (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({y, x}),
    .wdata (op_color),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

endmodule
